// ===== design/ille_pkg.sv =====
// Shared types and constants for the indexed linked list engine.
// No dependencies; imported by every module of the block except ille_ram.
package ille_pkg;

   localparam int CAPACITY = 1024;
   localparam int SLOT_W   = 10;
   localparam int LINK_W   = SLOT_W + 1;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 10;
   localparam int QUEUE_DEPTH = 2;

   // link codes: msb set means no link
   localparam logic [LINK_W-1:0] NULL_LINK = {LINK_W{1'b1}};
   localparam logic [LINK_W-1:0] CAP_LINK  = LINK_W'(CAPACITY);

   // request function codes
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_ERASE  = 2'd1;
   localparam logic [1:0] FUNC_READ   = 2'd2;

   // response status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_BAD  = 2'd2;

   typedef struct packed {
      logic                       is_insert;
      logic                       is_erase;
      logic                       is_read;
      logic                       is_head;
      logic [SLOT_W-1:0]          addr;
      logic signed [VALUE_W-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic [1:0]                 status;
      logic [SLOT_W-1:0]          new_slot;
      logic signed [VALUE_W-1:0]  node_value;
      logic [SLOT_W-1:0]          next_slot;
      logic                       has_next;
      logic [SLOT_W-1:0]          prev_slot;
      logic                       has_prev;
      logic [COUNT_W-1:0]         count;
   } rsp_type;

endpackage

// ===== design/indexed_linked_list_engine.sv =====
// Top level of the indexed linked list engine: front end, queue, back end.
// Depends on ille_pkg, ille_front, ille_back (and ille_ram through ille_back).
//
// Usage:
//  - Request channel (req_valid/req_ready): one item per operation. req_func
//    selects insert after req_addr, erase req_addr or read node req_addr;
//    req_value is the data stored by an insert.
//  - Response channel (rsp_valid/rsp_ready): exactly one item per request,
//    in request order: status, new slot, node value and links, list length.
//  - Sequence: an accepted request is queued; the back end pops it, reads
//    the stores (S_DATA) and registers the response; a successful insert
//    first passes through a splice step (S_FIX) that writes the link RAMs
//    again. The back end works on one item at a time and pops no new
//    command before it is done with the last one.
//  - Reset (synchronous, active high): list empty, next free slot 1. No
//    clearing pass: slots at or above the next free slot are never read,
//    and the head's forward link is masked by a flag until first written.
//  - Receiver stall: the result waits in the output register, the next one
//    in a hold register; a 2-entry queue keeps req_ready high meanwhile and
//    drops it only when that queue is full.
module indexed_linked_list_engine import ille_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_func,
   input  logic [SLOT_W-1:0]         req_addr,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic [SLOT_W-1:0]         rsp_new_slot,
   output logic signed [VALUE_W-1:0] rsp_node_value,
   output logic [SLOT_W-1:0]         rsp_next_slot,
   output logic                      rsp_has_next,
   output logic [SLOT_W-1:0]         rsp_prev_slot,
   output logic                      rsp_has_prev,
   output logic [COUNT_W-1:0]        rsp_count
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;
   rsp_type rsp;

   // decode and queue
   ille_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_addr  (req_addr),
      .req_value (req_value),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // store sequencer and response register
   ille_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_status     = rsp.status;
   assign rsp_new_slot   = rsp.new_slot;
   assign rsp_node_value = rsp.node_value;
   assign rsp_next_slot  = rsp.next_slot;
   assign rsp_has_next   = rsp.has_next;
   assign rsp_prev_slot  = rsp.prev_slot;
   assign rsp_has_prev   = rsp.has_prev;
   assign rsp_count      = rsp.count;

endmodule

// ===== design/ille_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module ille_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ille_front.sv =====
// Front end: takes request items, decodes the function, queues commands.
// Depends on ille_pkg.
module ille_front import ille_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_func,
   input  logic [SLOT_W-1:0]         req_addr,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      cmd_valid,
   output cmd_type                   cmd,
   input  logic                      cmd_pop
);

   cmd_type    slot_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   cmd_type    decoded;

   always_comb begin
      decoded.is_insert = (req_func == FUNC_INSERT);
      decoded.is_erase  = (req_func == FUNC_ERASE);
      decoded.is_read   = (req_func == FUNC_READ);
      decoded.is_head   = (req_addr == '0);
      decoded.addr      = req_addr;
      decoded.value     = req_value;
   end

   assign req_ready = (fill_ff != 2'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== design/ille_back.sv =====
// Back end: carries out queued commands on the value and link stores.
// Depends on ille_pkg and ille_ram.
module ille_back import ille_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DATA = 2'd1;
   localparam logic [1:0] S_FIX  = 2'd2;
   localparam logic [1:0] S_HOLD = 2'd3;

   logic [1:0]         state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [LINK_W-1:0]  succ_ff, succ_in;
   logic [LINK_W-1:0]  next_free_ff, next_free_in;
   logic [COUNT_W-1:0] length_ff, length_in;
   logic               head_linked_ff, head_linked_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   rsp_type            hold_ff, hold_in;

   logic               val_we, prev_we, next_we;
   logic [SLOT_W-1:0]  val_wa, prev_wa, next_wa;
   logic [VALUE_W-1:0] val_wd;
   logic [LINK_W-1:0]  prev_wd, next_wd;
   logic [VALUE_W-1:0] val_rd;
   logic [LINK_W-1:0]  prev_rd, next_rd;

   logic               finish;
   rsp_type            res;
   logic               out_free;
   logic               allocated;
   logic               full;
   logic [SLOT_W-1:0]  fresh;
   logic [LINK_W-1:0]  succ, pred;

   assign cmd_pop = (state_ff == S_IDLE) && cmd_valid;

   ille_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_value (
      .clock(clock), .wr_en(val_we), .wr_addr(val_wa), .wr_data(val_wd),
      .rd_en(cmd_pop), .rd_addr(cmd.addr), .rd_data(val_rd)
   );
   ille_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_prev (
      .clock(clock), .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_en(cmd_pop), .rd_addr(cmd.addr), .rd_data(prev_rd)
   );
   ille_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_next (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_en(cmd_pop), .rd_addr(cmd.addr), .rd_data(next_rd)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign allocated = ({1'b0, cmd_ff.addr} < next_free_ff);
   assign full      = (next_free_ff == CAP_LINK);
   assign fresh     = next_free_ff[SLOT_W-1:0];
   // slot 0 links are never written at allocation; mask them
   assign succ      = (cmd_ff.is_head && !head_linked_ff) ? NULL_LINK : next_rd;
   assign pred      = cmd_ff.is_head ? NULL_LINK : prev_rd;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      succ_in        = succ_ff;
      next_free_in   = next_free_ff;
      length_in      = length_ff;
      head_linked_in = head_linked_ff;
      val_we  = 1'b0;
      prev_we = 1'b0;
      next_we = 1'b0;
      val_wa  = fresh;
      prev_wa = fresh;
      next_wa = fresh;
      val_wd  = cmd_ff.value;
      prev_wd = {1'b0, cmd_ff.addr};
      next_wd = succ;
      finish  = 1'b0;
      res       = '0;
      res.count = length_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in   = cmd;
               state_in = S_DATA;
            end
         end
         S_DATA: begin
            priority if (cmd_ff.is_insert) begin
               priority if (!allocated) begin
                  res.status = STATUS_BAD;
                  finish     = 1'b1;
               end else if (full) begin
                  res.status = STATUS_FULL;
                  finish     = 1'b1;
               end else begin
                  // new node: value, successor and predecessor links
                  val_we   = 1'b1;
                  prev_we  = 1'b1;
                  next_we  = 1'b1;
                  succ_in  = succ;
                  state_in = S_FIX;
               end
            end else if (cmd_ff.is_erase) begin
               if (cmd_ff.is_head || !allocated) begin
                  res.status = STATUS_BAD;
               end else begin
                  next_we = !pred[SLOT_W];
                  next_wa = pred[SLOT_W-1:0];
                  next_wd = succ;
                  prev_we = !succ[SLOT_W];
                  prev_wa = succ[SLOT_W-1:0];
                  prev_wd = pred;
                  if (!pred[SLOT_W] && pred[SLOT_W-1:0] == '0) begin
                     head_linked_in = 1'b1;
                  end
                  if (length_ff != '0) begin
                     length_in = length_ff - 1'b1;
                  end
                  res.count = length_in;
               end
               finish = 1'b1;
            end else if (cmd_ff.is_read) begin
               if (!allocated) begin
                  res.status = STATUS_BAD;
               end else begin
                  res.node_value = cmd_ff.is_head ? '0 : $signed(val_rd);
                  if (!succ[SLOT_W]) begin
                     res.next_slot = succ[SLOT_W-1:0];
                     res.has_next  = 1'b1;
                  end
                  if (!pred[SLOT_W]) begin
                     res.prev_slot = pred[SLOT_W-1:0];
                     res.has_prev  = 1'b1;
                  end
               end
               finish = 1'b1;
            end else begin
               finish = 1'b1;
            end
         end
         S_FIX: begin
            // splice: old successor points back, predecessor points forward
            prev_we = !succ_ff[SLOT_W];
            prev_wa = succ_ff[SLOT_W-1:0];
            prev_wd = {1'b0, fresh};
            next_we = 1'b1;
            next_wa = cmd_ff.addr;
            next_wd = {1'b0, fresh};
            if (cmd_ff.is_head) begin
               head_linked_in = 1'b1;
            end
            next_free_in = next_free_ff + 1'b1;
            length_in    = length_ff + 1'b1;
            res.new_slot = fresh;
            res.count    = length_in;
            finish       = 1'b1;
         end
         S_HOLD: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         state_in = out_free ? S_IDLE : S_HOLD;
      end
   end

   // output register, with a hold register behind it when the sink stalls
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      hold_in      = hold_ff;
      if (finish) begin
         if (out_free) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
         end else begin
            hold_in = res;
         end
      end else if (state_ff == S_HOLD && out_free) begin
         rsp_in       = hold_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         next_free_ff   <= LINK_W'(1);
         length_ff      <= '0;
         head_linked_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         next_free_ff   <= next_free_in;
         length_ff      <= length_in;
         head_linked_ff <= head_linked_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cmd_ff  <= cmd_in;
      succ_ff <= succ_in;
      rsp_ff  <= rsp_in;
      hold_ff <= hold_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== bench/list_response_checker.sv =====
// Response checker for the indexed linked list engine: mirrors the list
// stores, predicts one response per accepted request and compares in order.
// Depends on ille_pkg for widths, codes and the response struct.
module list_response_checker import ille_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [1:0]                req_func,
   input  logic [SLOT_W-1:0]         req_addr,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [1:0]                rsp_status,
   input  logic [SLOT_W-1:0]         rsp_new_slot,
   input  logic signed [VALUE_W-1:0] rsp_node_value,
   input  logic [SLOT_W-1:0]         rsp_next_slot,
   input  logic                      rsp_has_next,
   input  logic [SLOT_W-1:0]         rsp_prev_slot,
   input  logic                      rsp_has_prev,
   input  logic [COUNT_W-1:0]        rsp_count,
   output int                        fail_count,
   output int                        outstanding,
   output int                        checked
);

   // mirror of the list stores
   logic signed [VALUE_W-1:0] node_vals [CAPACITY];
   logic [LINK_W-1:0]         prev_of   [CAPACITY];
   logic [LINK_W-1:0]         next_of   [CAPACITY];
   int                        first_unused;
   int                        node_total;

   rsp_type expected_rsps [$];

   // apply one operation to the mirror and return the response it should give
   function automatic rsp_type apply_list_op(input logic [1:0] op,
                                             input logic [SLOT_W-1:0] slot,
                                             input logic signed [VALUE_W-1:0] data);
      rsp_type           r;
      logic [LINK_W-1:0] succ;
      logic [LINK_W-1:0] pred;
      r = '0;
      case (op)
         FUNC_INSERT: begin
            if (slot >= first_unused) begin
               r.status = STATUS_BAD;
            end else if (first_unused >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else begin
               succ = next_of[slot];
               node_vals[first_unused] = data;
               next_of[first_unused]   = succ;
               prev_of[first_unused]   = LINK_W'(slot);
               if (succ != NULL_LINK && succ < CAP_LINK)
                  prev_of[succ[SLOT_W-1:0]] = LINK_W'(first_unused);
               next_of[slot] = LINK_W'(first_unused);
               r.status   = STATUS_OK;
               r.new_slot = SLOT_W'(first_unused);
               first_unused++;
               node_total++;
            end
         end
         FUNC_ERASE: begin
            if (slot == 0 || slot >= first_unused) begin
               r.status = STATUS_BAD;
            end else begin
               // stale links are used as-is: double erase is not caught
               pred = prev_of[slot];
               succ = next_of[slot];
               if (pred != NULL_LINK && pred < CAP_LINK)
                  next_of[pred[SLOT_W-1:0]] = succ;
               if (succ != NULL_LINK && succ < CAP_LINK)
                  prev_of[succ[SLOT_W-1:0]] = pred;
               if (node_total > 0)
                  node_total--;
               r.status = STATUS_OK;
            end
         end
         FUNC_READ: begin
            if (slot >= first_unused) begin
               r.status = STATUS_BAD;
            end else begin
               r.status     = STATUS_OK;
               r.node_value = (slot == 0) ? '0 : node_vals[slot];
               if (next_of[slot] != NULL_LINK) begin
                  r.next_slot = next_of[slot][SLOT_W-1:0];
                  r.has_next  = 1'b1;
               end
               if (prev_of[slot] != NULL_LINK) begin
                  r.prev_slot = prev_of[slot][SLOT_W-1:0];
                  r.has_prev  = 1'b1;
               end
            end
         end
         default: r.status = STATUS_OK;
      endcase
      r.count = COUNT_W'(node_total);
      return r;
   endfunction

   task automatic compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: response %0d field %s: expected %0d, actual %0d",
                  $time, checked, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      int      k;
      if (reset) begin
         for (k = 0; k < CAPACITY; k++) begin
            node_vals[k] = '0;
            prev_of[k]   = NULL_LINK;
            next_of[k]   = NULL_LINK;
         end
         first_unused = 1;
         node_total   = 0;
         expected_rsps.delete();
         fail_count = 0;
         checked    = 0;
      end else begin
         if (req_valid && req_ready)
            expected_rsps.push_back(apply_list_op(req_func, req_addr, req_value));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: response with none expected: expected nothing, actual status %0d",
                        $time, rsp_status);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               compare_field("status",     want.status,     rsp_status);
               compare_field("new_slot",   want.new_slot,   rsp_new_slot);
               compare_field("node_value", want.node_value, rsp_node_value);
               compare_field("next_slot",  want.next_slot,  rsp_next_slot);
               compare_field("has_next",   want.has_next,   rsp_has_next);
               compare_field("prev_slot",  want.prev_slot,  rsp_prev_slot);
               compare_field("has_prev",   want.has_prev,   rsp_has_prev);
               compare_field("count",      want.count,      rsp_count);
               checked++;
            end
         end
      end
      outstanding <= expected_rsps.size();
   end

endmodule

// ===== bench/testbench.sv =====
// Top of the linked list engine bench: clock, reset, request stimulus,
// receiver pacing and the verdict. Depends on ille_pkg, the engine RTL and
// list_response_checker, which does all prediction and comparison.
module testbench import ille_pkg::*; ();

   // func 3 has no operation behind it
   localparam logic [1:0] FUNC_NONE = 2'd3;
   localparam int RANDOM_OPS  = 420;
   localparam int TAIL_OPS    = 40;
   // limit sized for ~490 items with full gaps and stalls
   localparam int CYCLE_LIMIT = 100000;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_func  = FUNC_READ;
   logic [SLOT_W-1:0]         req_addr  = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [1:0]                rsp_status;
   logic [SLOT_W-1:0]         rsp_new_slot;
   logic signed [VALUE_W-1:0] rsp_node_value;
   logic [SLOT_W-1:0]         rsp_next_slot;
   logic                      rsp_has_next;
   logic [SLOT_W-1:0]         rsp_prev_slot;
   logic                      rsp_has_prev;
   logic [COUNT_W-1:0]        rsp_count;

   int fail_count;
   int outstanding;
   int checked;
   int cycle_count = 0;

   // Stimulus-side bookkeeping only: which slots exist and which are still
   // linked, so most requests hit real nodes. Not used for checking.
   int alloc_mark = 1;
   int live_nodes [$];
   int dead_nodes [$];
   int op_tally   [4] = '{0, 0, 0, 0};
   bit quiet_tail = 1'b0;   // set for the last stretch: no gaps, no stalls

   indexed_linked_list_engine i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_addr       (req_addr),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_new_slot   (rsp_new_slot),
      .rsp_node_value (rsp_node_value),
      .rsp_next_slot  (rsp_next_slot),
      .rsp_has_next   (rsp_has_next),
      .rsp_prev_slot  (rsp_prev_slot),
      .rsp_has_prev   (rsp_has_prev),
      .rsp_count      (rsp_count)
   );

   list_response_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_addr       (req_addr),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_new_slot   (rsp_new_slot),
      .rsp_node_value (rsp_node_value),
      .rsp_next_slot  (rsp_next_slot),
      .rsp_has_next   (rsp_has_next),
      .rsp_prev_slot  (rsp_prev_slot),
      .rsp_has_prev   (rsp_has_prev),
      .rsp_count      (rsp_count),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .checked        (checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the engine hangs on either channel.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses still expected",
                  cycle_count, outstanding);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Receiver pacing: ready stretches broken by stall bursts, both of random
   // length. Stalls stop once the quiet tail begins.
   initial begin : rsp_pacing
      int stall;
      @(posedge clock);
      forever begin
         if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 19);
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   // Send one item. An optional idle gap of random length goes first; valid
   // then stays high with a stable payload until the engine takes the item.
   task automatic issue(input logic [1:0] op, input int slot, input logic [31:0] data);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= op;
      req_addr  <= SLOT_W'(slot);
      req_value <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // a good insert takes the next fresh slot
      if (op == FUNC_INSERT && slot < alloc_mark && alloc_mark < CAPACITY) begin
         live_nodes.push_back(alloc_mark);
         alloc_mark++;
      end
      op_tally[op]++;
   endtask

   // data with the sign and range extremes showing up often
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // insert position: the head now and then, otherwise a linked node
   function automatic int pick_anchor();
      if (live_nodes.size() == 0 || $urandom_range(0, 4) == 0)
         return 0;
      return live_nodes[$urandom_range(0, live_nodes.size() - 1)];
   endfunction

   // unlink a random live node and remember it as erased
   task automatic erase_live();
      int idx;
      int node;
      idx  = $urandom_range(0, live_nodes.size() - 1);
      node = live_nodes[idx];
      live_nodes.delete(idx);
      dead_nodes.push_back(node);
      issue(FUNC_ERASE, node, pick_value());
   endtask

   initial begin : stimulus
      int sel;
      int n;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: empty list, bad addresses, unused code ---
      issue(FUNC_READ,   0,    32'h0);           // head of empty list
      issue(FUNC_READ,   1,    32'h0);           // not allocated yet
      issue(FUNC_ERASE,  0,    32'h0);           // head cannot be erased
      issue(FUNC_ERASE,  1,    32'h0);           // not allocated yet
      issue(FUNC_INSERT, 1,    32'h1234_5678);   // anchor not allocated
      issue(FUNC_NONE,   1023, 32'hFFFF_FFFF);   // no-op code

      // --- directed: one node, erased twice; length must stay at zero ---
      issue(FUNC_INSERT, 0, 32'h7FFF_FFFF);      // slot 1
      live_nodes.delete();
      dead_nodes.push_back(1);
      issue(FUNC_ERASE, 1, 32'h0);
      issue(FUNC_ERASE, 1, 32'h0);
      issue(FUNC_READ,  1, 32'h0);               // stale links of erased node

      // --- directed: insert behind an erased node, then build head->5->3->4 ---
      issue(FUNC_INSERT, 1, 32'h8000_0000);      // slot 2 via stale links
      issue(FUNC_INSERT, 0, 32'h0000_0000);      // slot 3
      issue(FUNC_INSERT, 3, 32'hFFFF_FFFF);      // slot 4 after 3 (tail)
      issue(FUNC_INSERT, 0, 32'h0000_0005);      // slot 5 at the front
      issue(FUNC_READ, 0, 32'h0);
      issue(FUNC_READ, 5, 32'h0);
      issue(FUNC_READ, 3, 32'h0);
      issue(FUNC_READ, 4, 32'h0);

      // middle unlink, then look at both neighbours
      live_nodes = '{2, 5, 4};
      dead_nodes.push_back(3);
      issue(FUNC_ERASE, 3, 32'h0);
      issue(FUNC_READ,  5, 32'h0);
      issue(FUNC_READ,  4, 32'h0);

      // top slot before it exists
      issue(FUNC_READ,   1023, 32'h0);
      issue(FUNC_INSERT, 1023, 32'h0);
      issue(FUNC_ERASE,  1023, 32'h0);

      // --- random: mostly well-formed list traffic, some stale and noise ---
      for (n = 0; n < RANDOM_OPS; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 42)
            issue(FUNC_INSERT, pick_anchor(), pick_value());
         else if (sel < 46 && dead_nodes.size() > 0)
            issue(FUNC_INSERT, dead_nodes[$urandom_range(0, dead_nodes.size() - 1)],
                  pick_value());
         else if (sel < 62 && live_nodes.size() > 0)
            erase_live();
         else if (sel < 65 && dead_nodes.size() > 0)
            issue(FUNC_ERASE, dead_nodes[$urandom_range(0, dead_nodes.size() - 1)],
                  pick_value());
         else if (sel < 92)
            issue(FUNC_READ, $urandom_range(0, alloc_mark - 1), pick_value());
         else
            issue(2'($urandom_range(0, 3)), $urandom_range(0, 1023), $urandom());
      end

      // --- quiet tail: top slot still unallocated, then random traffic ---
      quiet_tail = 1'b1;
      issue(FUNC_INSERT, 1023, 32'h8000_0000);   // anchor not allocated
      issue(FUNC_READ,   1023, 32'h0);
      issue(FUNC_ERASE,  1023, 32'h0);
      issue(FUNC_READ,   0,    32'h0);
      for (n = 0; n < TAIL_OPS; n++) begin
         sel = $urandom_range(0, 9);
         if (sel < 5)
            issue(FUNC_READ, $urandom_range(0, 1023), pick_value());
         else if (sel < 8 && live_nodes.size() > 0)
            erase_live();
         else if (sel == 8)
            issue(FUNC_INSERT, pick_anchor(), pick_value());
         else
            issue(FUNC_NONE, $urandom_range(0, 1023), $urandom());
      end
      req_valid <= 1'b0;

      // drain: every prediction answered, then an idle stretch for strays
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Sent %0d items: %0d inserts, %0d erases, %0d reads, %0d no-ops",
               op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
               op_tally[FUNC_INSERT], op_tally[FUNC_ERASE], op_tally[FUNC_READ],
               op_tally[FUNC_NONE]);
      $display("%0d responses checked; %0d of %0d slots handed out, stale links hit",
               checked, alloc_mark, CAPACITY);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
